@@ rtl/core/mps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;
   localparam int Capacity = 64;
   localparam int AddrW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);
   localparam logic [19:0] ValueMax = 20'd1000000;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_EXTRACT = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_EMPTY = 2'd1,
      ST_DUP = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_PLACE,
      S_TOP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [19:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [19:0] removed_value;
      logic [6:0] entry_count;
      logic [19:0] top_value;
   } rsp_type;

   typedef struct packed {
      logic we;
      logic [AddrW-1:0] waddr;
      logic [19:0] wdata;
      logic [AddrW-1:0] raddr;
   } mem_ctl_type;
endpackage
`default_nettype wire

@@ rtl/core/mps_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mps_store (
   input wire logic clock,
   input wire mps_pkg::mem_ctl_type ctl,
   output logic [19:0] rdata
);
   import mps_pkg::*;

   logic [19:0] mem [Capacity];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata <= mem[ctl.raddr];
   end
endmodule
`default_nettype wire

@@ rtl/core/mps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mps_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire mps_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output mps_pkg::rsp_type rsp_data,
   output mps_pkg::mem_ctl_type ctl,
   input wire logic [19:0] rdata
);
   import mps_pkg::*;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [19:0] val_ff, val_in;
   logic [1:0] status_ff, status_in;
   logic [19:0] removed_ff, removed_in;
   logic [19:0] top_ff, top_in;
   logic pend_ff, pend_in;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;
   logic accept, out_free;
   logic [CntW-1:0] found_pos;

   // The search reads entry idx_ff-1; the new value belongs just above the
   // first entry that is smaller, or at the bottom.
   assign found_pos = (rdata < val_ff) ? idx_ff : '0;
   assign out_free = !rv_ff || !rsp_stall;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            if (mode_type'(req_data.mode) == MODE_INSERT && count_ff != '0) begin
               state_in = S_SEARCH;
            end else if (mode_type'(req_data.mode) == MODE_EXTRACT
                         && count_ff > CntW'(1)) begin
               state_in = S_TOP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SEARCH: if (pend_ff) begin
            if (rdata == val_ff) begin
               state_in = S_DONE;
            end else if (rdata < val_ff || idx_ff == CntW'(1)) begin
               if (count_ff == CntW'(Capacity) || found_pos == count_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: if (pend_ff && (idx_ff - CntW'(1)) == pos_ff) state_in = S_PLACE;
         S_PLACE: state_in = S_DONE;
         S_TOP: if (pend_ff) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      val_in = val_ff;
      status_in = status_ff;
      removed_in = removed_ff;
      top_in = top_ff;
      pend_in = 1'b0;
      ctl = '0;
      rsp_in = rsp_ff;
      rv_in = rv_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            val_in = (req_data.item_value > ValueMax) ? ValueMax : req_data.item_value;
            status_in = ST_OK;
            removed_in = '0;
            idx_in = count_ff;
            unique case (mode_type'(req_data.mode))
               MODE_INSERT: begin
                  if (count_ff == '0) begin
                     ctl.we = 1'b1;
                     ctl.waddr = '0;
                     ctl.wdata = val_in;
                     count_in = CntW'(1);
                     top_in = val_in;
                  end else begin
                     ctl.raddr = AddrW'(count_ff - CntW'(1));
                     pend_in = 1'b1;
                  end
               end
               MODE_EXTRACT: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     removed_in = top_ff;
                     count_in = count_ff - CntW'(1);
                     if (count_ff == CntW'(1)) top_in = '0;
                     else begin
                        ctl.raddr = AddrW'(count_ff - CntW'(2));
                        pend_in = 1'b1;
                     end
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
                  top_in = '0;
               end
               default: ;
            endcase
         end
         S_SEARCH: if (pend_ff) begin
            if (rdata == val_ff) begin
               status_in = ST_DUP;
            end else if (rdata < val_ff || idx_ff == CntW'(1)) begin
               if (count_ff == CntW'(Capacity)) begin
                  status_in = ST_FULL;
               end else if (found_pos == count_ff) begin
                  ctl.we = 1'b1;
                  ctl.waddr = AddrW'(count_ff);
                  ctl.wdata = val_ff;
                  count_in = count_ff + CntW'(1);
                  top_in = val_ff;
               end else begin
                  ctl.raddr = AddrW'(count_ff - CntW'(1));
                  pend_in = 1'b1;
                  idx_in = count_ff;
                  pos_in = found_pos;
               end
            end else begin
               ctl.raddr = AddrW'(idx_ff - CntW'(2));
               pend_in = 1'b1;
               idx_in = idx_ff - CntW'(1);
            end
         end
         S_SHIFT: if (pend_ff) begin
            ctl.we = 1'b1;
            ctl.waddr = AddrW'(idx_ff);
            ctl.wdata = rdata;
            if ((idx_ff - CntW'(1)) != pos_ff) begin
               ctl.raddr = AddrW'(idx_ff - CntW'(2));
               pend_in = 1'b1;
               idx_in = idx_ff - CntW'(1);
            end
         end
         S_PLACE: begin
            ctl.we = 1'b1;
            ctl.waddr = AddrW'(pos_ff);
            ctl.wdata = val_ff;
            count_in = count_ff + CntW'(1);
         end
         S_TOP: if (pend_ff) top_in = rdata;
         S_DONE: if (out_free) begin
            rsp_in.status = status_ff;
            rsp_in.removed_value = removed_ff;
            rsp_in.entry_count = 7'(count_ff);
            rsp_in.top_value = top_ff;
            rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         top_ff <= '0;
         pend_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff <= top_in;
         pend_ff <= pend_in;
         rv_ff <= rv_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      status_ff <= status_in;
      removed_ff <= removed_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

@@ rtl/core/max_priority_set.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Payload
// req      in         mode, item_value
// rsp      out        status, removed_value, entry_count, top_value
// An insert reads down from the top entry one entry at a time, then moves the
// larger entries up one place each and writes the new value into the gap; an
// extract from a set of two or more entries reads the entry below the top.
// A new request is taken only once the last one is done; the pace is set by
// the single read port of the entry memory.
// Reset empties the set at once. A stalled response holds the next request off.
module max_priority_set (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire mps_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output mps_pkg::rsp_type rsp_data
);
   import mps_pkg::*;

   mem_ctl_type ctl;
   logic [19:0] rdata;

   mps_store u_store (
      .clock(clock),
      .ctl(ctl),
      .rdata(rdata)
   );

   mps_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .ctl(ctl),
      .rdata(rdata)
   );
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import mps_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   max_priority_set i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   logic [19:0] set_entries[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   bit stimulus_done = 1'b0;

   // Ascending order is kept, so the largest stored value is the last entry.
   function automatic rsp_type predict_set_step(req_type r);
      rsp_type o;
      logic [19:0] v;
      int pos;
      o = '0;
      o.status = ST_OK;
      case (r.mode)
         MODE_INSERT: begin
            v = (r.item_value > ValueMax) ? ValueMax : r.item_value;
            pos = 0;
            while (pos < set_entries.size() && set_entries[pos] < v) pos++;
            if (pos < set_entries.size() && set_entries[pos] == v) begin
               o.status = ST_DUP;
            end else if (set_entries.size() >= Capacity) begin
               o.status = ST_FULL;
            end else begin
               set_entries.insert(pos, v);
            end
         end
         MODE_EXTRACT: begin
            if (set_entries.size() == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.removed_value = set_entries.pop_back();
            end
         end
         MODE_CLEAR: begin
            set_entries.delete();
         end
         default: begin
         end
      endcase
      o.entry_count = 7'(set_entries.size());
      o.top_value = (set_entries.size() == 0) ? 20'd0 : set_entries[$];
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs[0];
               expected_rsps.push_back(predict_set_step(pending_reqs[0]));
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.removed_value !== e.removed_value) begin
               $error("removed_value expected %0d actual %0d", e.removed_value,
                  rsp_data.removed_value);
               error_count++;
            end
            if (rsp_data.entry_count !== e.entry_count) begin
               $error("entry_count expected %0d actual %0d", e.entry_count,
                  rsp_data.entry_count);
               error_count++;
            end
            if (rsp_data.top_value !== e.top_value) begin
               $error("top_value expected %0d actual %0d", e.top_value, rsp_data.top_value);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic req_type make_req(mode_type m, logic [19:0] v);
      req_type r;
      r.mode = m;
      r.item_value = v;
      return r;
   endfunction

   task automatic add_random_requests(int n);
      int k;
      int pick;
      logic [19:0] v;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         v = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(1000000));
         if ($urandom_range(3) == 0) v = 20'($urandom_range(80));
         if (pick < 55) pending_reqs.push_back(make_req(MODE_INSERT, v));
         else if (pick < 93) pending_reqs.push_back(make_req(MODE_EXTRACT, v));
         else if (pick < 96) pending_reqs.push_back(make_req(MODE_CLEAR, v));
         else pending_reqs.push_back(make_req(MODE_NONE, v));
      end
   endtask

   initial begin
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      pending_reqs.push_back(make_req(MODE_EXTRACT, 20'hFFFFF));
      pending_reqs.push_back(make_req(MODE_INSERT, 20'd0));
      pending_reqs.push_back(make_req(MODE_INSERT, 20'd1000000));
      pending_reqs.push_back(make_req(MODE_INSERT, 20'hFFFFF));
      pending_reqs.push_back(make_req(MODE_INSERT, 20'd0));
      pending_reqs.push_back(make_req(MODE_INSERT, 20'h55555));
      pending_reqs.push_back(make_req(MODE_NONE, 20'hAAAAA));
      pending_reqs.push_back(make_req(MODE_EXTRACT, 20'd0));
      pending_reqs.push_back(make_req(MODE_CLEAR, 20'd7));
      pending_reqs.push_back(make_req(MODE_EXTRACT, 20'd0));
      for (k = 0; k < 66; k++) pending_reqs.push_back(make_req(MODE_INSERT, 20'(k * 3)));
      pending_reqs.push_back(make_req(MODE_INSERT, 20'd9));
      add_random_requests(560);
      send_idle_pct = 6;
      recv_idle_pct = 54;
      wait (pending_reqs.size() == 0);
      add_random_requests(600);
      send_idle_pct = 54;
      recv_idle_pct = 6;
      wait (pending_reqs.size() == 0);
      for (k = 0; k < 70; k++) pending_reqs.push_back(make_req(MODE_INSERT, 20'($urandom)));
      add_random_requests(560);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
